FILE: hw/rtl/slpc_pkg.sv
// Package for the slope and direction point classifier.
// Holds shared widths, register indexes, the sequencer state type and the angle table.
// No dependencies.
package slpc_pkg;

   localparam int DEF_MAX_CENTERS = 8;
   localparam int DEF_COORD_BITS  = 12;
   localparam int DEF_FRAC_BITS   = 12;

   localparam int VAL_W       = 26;
   localparam int IDX_OUT_W   = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CORDIC_N    = 24;
   localparam int ANG_SCALE   = 24;
   localparam int VEC_SHIFT   = 20;
   localparam int Z_W         = 33;
   localparam int STEP_W      = 6;
   localparam int THRESHOLD   = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_REF = 2'd2;

   localparam logic ACT_LOAD     = 1'b0;
   localparam logic ACT_CLASSIFY = 1'b1;
   localparam logic MODE_SLOPE   = 1'b0;
   localparam logic MODE_ANGLE   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SETUP,
      ST_ITER,
      ST_MEAS,
      ST_DIFF,
      ST_CMP,
      ST_DONE
   } state_type;

   function automatic logic signed [Z_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
      logic signed [Z_W-1:0] v;
      case (i)
         6'd0:  v = 33'sd754974720;
         6'd1:  v = 33'sd445687602;
         6'd2:  v = 33'sd235489088;
         6'd3:  v = 33'sd119537938;
         6'd4:  v = 33'sd60000934;
         6'd5:  v = 33'sd30029717;
         6'd6:  v = 33'sd15018523;
         6'd7:  v = 33'sd7509720;
         6'd8:  v = 33'sd3754917;
         6'd9:  v = 33'sd1877466;
         6'd10: v = 33'sd938734;
         6'd11: v = 33'sd469367;
         6'd12: v = 33'sd234684;
         6'd13: v = 33'sd117342;
         6'd14: v = 33'sd58671;
         6'd15: v = 33'sd29335;
         6'd16: v = 33'sd14668;
         6'd17: v = 33'sd7334;
         6'd18: v = 33'sd3667;
         6'd19: v = 33'sd1833;
         6'd20: v = 33'sd917;
         6'd21: v = 33'sd458;
         6'd22: v = 33'sd229;
         6'd23: v = 33'sd115;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/slope_direction_point_classifier.sv
// Slope and direction point classifier: center table, shared CORDIC or divider unit, sequencer.
// Depends on slpc_pkg.
// The sequencer visits the active centers in turn: ST_FETCH, ST_SETUP, the shared unit in
// ST_ITER and ST_MEAS, then ST_DIFF and ST_CMP. The unit runs 24 CORDIC steps in angle mode,
// COORD_BITS + FRAC_BITS divider steps in slope mode. A center with dx or dy of zero skips the
// unit, and a slope scan ends at ST_SETUP of a center with dx of zero. req_tready returns with
// the response; loads are taken in ST_IDLE. A stalled response holds the block in ST_DONE.
// Synchronous active-high reset clears the sequencer, mode and references and sets count to one.
module slope_direction_point_classifier #(
   parameter int MAX_CENTERS = slpc_pkg::DEF_MAX_CENTERS,
   parameter int COORD_BITS  = slpc_pkg::DEF_COORD_BITS,
   parameter int FRAC_BITS   = slpc_pkg::DEF_FRAC_BITS,
   localparam int REQ_DATA_W = ((3 + 2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // center_index, coord_x, coord_y, zero fill
   input  logic [REQ_DATA_W-1:0]           req_tdata,
   // action, start_of_set
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cluster, measure, zero fill
   output logic [31:0]                     rsp_tdata,
   // matched
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [slpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slpc_pkg::VAL_W-1:0]      csr_data
);
   import slpc_pkg::*;

   localparam int IW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int KW    = $clog2(MAX_CENTERS + 1);
   localparam int Q_W   = COORD_BITS + FRAC_BITS;
   localparam int CW    = COORD_BITS + 23;
   localparam int AD_W  = FRAC_BITS + 4;
   localparam int SQ_W  = 2 * AD_W;
   localparam int RND_SH = ANG_SCALE - FRAC_BITS;
   localparam logic [SQ_W-1:0] THR = SQ_W'(THRESHOLD) << (2 * FRAC_BITS);
   localparam logic signed [Z_W-1:0] Z_LIM = Z_W'(90) << ANG_SCALE;
   localparam logic signed [VAL_W-1:0] ANG_90  = VAL_W'(90) << FRAC_BITS;
   localparam logic signed [VAL_W-1:0] ANG_180 = VAL_W'(180) << FRAC_BITS;
   localparam logic [63:0] VMAX = 64'((64'd1 << (VAL_W - 1)) - 64'd1);

   state_type state_ff, state_in;

   logic [COORD_BITS-1:0] tab_x_mem [MAX_CENTERS];
   logic [COORD_BITS-1:0] tab_y_mem [MAX_CENTERS];

   logic                     mode_ff, mode_in;
   logic [3:0]               count_ff, count_in;
   logic signed [VAL_W-1:0]  init_ref_ff, init_ref_in;
   logic signed [VAL_W-1:0]  ref_ff, ref_in;
   logic [COORD_BITS-1:0]    px_ff, px_in, py_ff, py_in;
   logic [COORD_BITS-1:0]    rd_x_ff, rd_y_ff;
   logic [KW-1:0]            k_ff, k_in, n_ff, n_in;
   logic                     found_ff, found_in;
   logic [KW-1:0]            best_k_ff, best_k_in;
   logic signed [VAL_W-1:0]  best_ff, best_in;
   logic [VAL_W:0]           best_ad_ff, best_ad_in;
   logic signed [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   logic [COORD_BITS-1:0]    rem_ff, rem_in, ax_ff, ax_in;
   logic [Q_W-1:0]           num_ff, num_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     neg_ff, neg_in;
   logic signed [VAL_W-1:0]  meas_ff, meas_in;
   logic [VAL_W:0]           ad_ff, ad_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_OUT_W-1:0]     rsp_cluster_ff, rsp_cluster_in;
   logic                     rsp_matched_ff, rsp_matched_in;
   logic signed [VAL_W-1:0]  rsp_meas_ff, rsp_meas_in;

   logic req_fire, load_req, skip_dx, dx_zero, dy_zero, last_step, out_free;
   logic signed [COORD_BITS:0] dx, dy;
   logic [COORD_BITS:0] trial;
   logic signed [CW-1:0] xs, ys;
   logic signed [Z_W-1:0] zc;
   logic signed [VAL_W-1:0] ang;
   logic [63:0] q64;
   logic signed [VAL_W:0] diff, rsum;
   logic [SQ_W-1:0] sq;
   logic [7:0] n_lim;
   logic hit;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign load_req   = (req_tuser[0] == ACT_LOAD);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_matched_ff;
   assign rsp_tdata  = 32'({rsp_meas_ff, rsp_cluster_ff});

   assign n_lim   = (8'(count_ff) > 8'(MAX_CENTERS)) ? 8'(MAX_CENTERS) : 8'(count_ff);
   assign dx      = $signed({1'b0, rd_x_ff}) - $signed({1'b0, px_ff});
   assign dy      = $signed({1'b0, rd_y_ff}) - $signed({1'b0, py_ff});
   assign dx_zero = (dx == '0);
   assign dy_zero = (dy == '0);
   assign skip_dx = dx_zero && (mode_ff == MODE_SLOPE);
   assign last_step = (mode_ff == MODE_SLOPE) ? (step_ff == STEP_W'(Q_W - 1))
                                               : (step_ff == STEP_W'(CORDIC_N - 1));

   always_ff @(posedge clock) begin
      if (req_fire && load_req && (32'(req_tdata[2:0]) < 32'(MAX_CENTERS))) begin
         tab_x_mem[IW'(req_tdata[2:0])] <= req_tdata[3 +: COORD_BITS];
         tab_y_mem[IW'(req_tdata[2:0])] <= req_tdata[3 + COORD_BITS +: COORD_BITS];
      end
      rd_x_ff <= tab_x_mem[k_ff[IW-1:0]];
      rd_y_ff <= tab_y_mem[k_ff[IW-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && !load_req) begin
               state_in = (n_lim == 8'd0) ? ST_DONE : ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_SETUP;
         ST_SETUP: begin
            if (skip_dx) begin
               state_in = ST_DONE;
            end else if (dx_zero || dy_zero) begin
               state_in = ST_DIFF;
            end else begin
               state_in = ST_ITER;
            end
         end
         ST_ITER:  state_in = last_step ? ST_MEAS : ST_ITER;
         ST_MEAS:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_CMP;
         ST_CMP:   state_in = (k_ff + KW'(1) == n_ff) ? ST_DONE : ST_FETCH;
         ST_DONE:  state_in = out_free ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      count_in = count_ff;
      init_ref_in = init_ref_ff;
      ref_in = ref_ff;
      px_in = px_ff;
      py_in = py_ff;
      k_in = k_ff;
      n_in = n_ff;
      found_in = found_ff;
      best_k_in = best_k_ff;
      best_in = best_ff;
      best_ad_in = best_ad_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      z_in = z_ff;
      rem_in = rem_ff;
      ax_in = ax_ff;
      num_in = num_ff;
      step_in = step_ff;
      neg_in = neg_ff;
      meas_in = meas_ff;
      ad_in = ad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_cluster_in = rsp_cluster_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_meas_in = rsp_meas_ff;

      xs = cx_ff >>> step_ff;
      ys = cy_ff >>> step_ff;
      trial = {rem_ff, num_ff[Q_W-1]};
      zc = (z_ff < 0) ? '0 : ((z_ff > Z_LIM) ? Z_LIM : z_ff);
      ang = VAL_W'((zc + (Z_W'(1) <<< (RND_SH - 1))) >>> RND_SH);
      q64 = 64'(num_ff);
      diff = $signed({meas_ff[VAL_W-1], meas_ff}) - $signed({ref_ff[VAL_W-1], ref_ff});
      sq = ad_ff[AD_W-1:0] * ad_ff[AD_W-1:0];
      hit = (ad_ff < (VAL_W+1)'(1 << AD_W)) && (sq < THR) && (!found_ff || ad_ff < best_ad_ff);
      rsum = $signed({ref_ff[VAL_W-1], ref_ff}) + $signed({best_ff[VAL_W-1], best_ff});

      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:     mode_in = csr_data[0];
            CSR_COUNT:    count_in = csr_data[3:0];
            CSR_INIT_REF: init_ref_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && !load_req) begin
               px_in = req_tdata[3 +: COORD_BITS];
               py_in = req_tdata[3 + COORD_BITS +: COORD_BITS];
               if (req_tuser[1]) begin
                  ref_in = init_ref_ff;
               end
               k_in = '0;
               n_in = KW'(n_lim);
               found_in = 1'b0;
               best_k_in = '0;
               best_in = '0;
               best_ad_in = '0;
            end
         end
         ST_SETUP: begin
            neg_in = dx[COORD_BITS] ^ dy[COORD_BITS];
            step_in = '0;
            z_in = '0;
            rem_in = '0;
            ax_in = COORD_BITS'(dx[COORD_BITS] ? -dx : dx);
            num_in = Q_W'($unsigned(COORD_BITS'(dy[COORD_BITS] ? -dy : dy))) << FRAC_BITS;
            cx_in = CW'($unsigned(COORD_BITS'(dx[COORD_BITS] ? -dx : dx))) << VEC_SHIFT;
            cy_in = CW'($unsigned(COORD_BITS'(dy[COORD_BITS] ? -dy : dy))) << VEC_SHIFT;
            if (dx_zero) begin
               meas_in = ANG_90;
            end else if (dy_zero) begin
               meas_in = '0;
            end
         end
         ST_ITER: begin
            step_in = step_ff + STEP_W'(1);
            if (mode_ff == MODE_SLOPE) begin
               if (trial >= {1'b0, ax_ff}) begin
                  rem_in = COORD_BITS'(trial - {1'b0, ax_ff});
               end else begin
                  rem_in = COORD_BITS'(trial);
               end
               num_in = {num_ff[Q_W-2:0], trial >= {1'b0, ax_ff}};
            end else if (cy_ff >= 0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               z_in = z_ff + atan_deg(step_ff);
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               z_in = z_ff - atan_deg(step_ff);
            end
         end
         ST_MEAS: begin
            if (mode_ff == MODE_SLOPE) begin
               if (!neg_ff) begin
                  meas_in = (q64 > VMAX) ? VAL_W'(VMAX) : VAL_W'(q64);
               end else begin
                  meas_in = (q64 > VMAX + 64'd1) ? VAL_W'(VMAX + 64'd1) : VAL_W'(-q64);
               end
            end else begin
               meas_in = neg_ff ? ANG_180 - ang : ang;
            end
         end
         ST_DIFF: begin
            ad_in = (VAL_W+1)'(diff[VAL_W] ? -diff : diff);
         end
         ST_CMP: begin
            if (hit) begin
               found_in = 1'b1;
               best_ad_in = ad_ff;
               best_k_in = k_ff;
               best_in = meas_ff;
            end
            k_in = k_ff + KW'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_matched_in = found_ff;
               rsp_cluster_in = found_ff ? IDX_OUT_W'(best_k_ff) : '0;
               rsp_meas_in = found_ff ? best_ff : '0;
               if (found_ff && mode_ff == MODE_SLOPE) begin
                  ref_in = VAL_W'((rsum + $signed((VAL_W+1)'(rsum[VAL_W] & rsum[0]))) >>> 1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= 1'b0;
         count_ff <= 4'd1;
         init_ref_ff <= '0;
         ref_ff <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         k_ff <= '0;
         n_ff <= '0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         count_ff <= count_in;
         init_ref_ff <= init_ref_in;
         ref_ff <= ref_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff <= found_in;
         k_ff <= k_in;
         n_ff <= n_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      best_k_ff <= best_k_in;
      best_ff <= best_in;
      best_ad_ff <= best_ad_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff <= z_in;
      rem_ff <= rem_in;
      ax_ff <= ax_in;
      num_ff <= num_in;
      neg_ff <= neg_in;
      meas_ff <= meas_in;
      ad_ff <= ad_in;
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_meas_ff <= rsp_meas_in;
   end

   a_busy_after_classify: assert property (@(posedge clock) disable iff (reset)
      req_fire && !load_req |=> !req_tready)
      else $error("Block ready right after taking a classify request.");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_matched_ff |-> rsp_tdata == '0)
      else $error("Rejected point carries a nonzero result.");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ITER |-> step_ff < STEP_W'(Q_W > CORDIC_N ? Q_W : CORDIC_N))
      else $error("Shared unit ran past its step count.");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> k_ff < n_ff)
      else $error("Center scan ran past the active count.");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for slope_direction_point_classifier: directed and random
// requests with a built-in predictor and a queue of expected outcomes.
// Depends on slpc_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
   import slpc_pkg::*;

   localparam int  TMAX       = 3000000;
   localparam int  DRAIN_WAIT = 300;
   localparam longint FULL    = 1 << 12;

   typedef struct {
      logic [2:0]        cluster;
      logic              matched;
      logic signed [25:0] measure;
   } outcome_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VAL_W-1:0] csr_data = '0;

   outcome_t pending_outcomes[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  stall_cycles = 0;

   logic [11:0] model_px[8];
   logic [11:0] model_py[8];
   longint reference;
   logic cfg_mode;
   logic [3:0] cfg_count;
   longint cfg_init_ref;

   slope_direction_point_classifier u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TMAX) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 15);
   endfunction

   always @(negedge clock) begin
      if (stall_cycles > 0) begin
         rsp_tready <= 1'b0;
         stall_cycles <= stall_cycles - 1;
      end else if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (pick_gap() == 0);
      end
   end

   // Base angle in degrees with 12 fraction bits, from a 24-step vectoring CORDIC.
   function automatic longint cordic_angle(longint ax, longint ay);
      longint x, y, z, xs, ys;
      x = ax <<< 20;
      y = ay <<< 20;
      z = 0;
      for (int i = 0; i < CORDIC_N; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(atan_deg(STEP_W'(i)));
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(atan_deg(STEP_W'(i)));
         end
      end
      if (z < 0) z = 0;
      if (z > (longint'(90) <<< 24)) z = longint'(90) <<< 24;
      return (z + (1 <<< 11)) >>> 12;
   endfunction

   function automatic outcome_t classify_point(longint px, longint py, logic sos);
      outcome_t o;
      longint dx, dy, m, diff, sq, best_sq, best, ax, ay;
      int n, best_k;
      logic found;
      found = 1'b0;
      best = 0;
      best_sq = 0;
      best_k = 0;
      if (sos) reference = cfg_init_ref;
      n = (cfg_count > 8) ? 8 : cfg_count;
      for (int k = 0; k < n; k++) begin
         dx = longint'(model_px[k]) - px;
         dy = longint'(model_py[k]) - py;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         if (cfg_mode != MODE_SLOPE) begin
            if (dx == 0) m = 90 * FULL;
            else if (dy == 0) m = 0;
            else begin
               m = cordic_angle(ax, ay);
               if ((dx < 0) != (dy < 0)) m = 180 * FULL - m;
            end
         end else begin
            if (dx == 0) break;
            m = (ay <<< 12) / ax;
            if ((dx < 0) != (dy < 0)) m = -m;
            if (m > 33554431) m = 33554431;
            if (m < -33554432) m = -33554432;
         end
         diff = m - reference;
         sq = diff * diff;
         if (sq < (longint'(THRESHOLD) <<< 24) && (!found || sq < best_sq)) begin
            found = 1'b1;
            best_sq = sq;
            best_k = k;
            best = m;
         end
      end
      o.cluster = found ? best_k[2:0] : 3'd0;
      o.matched = found;
      o.measure = found ? best[25:0] : 26'd0;
      if (found && cfg_mode == MODE_SLOPE) reference = (reference + best) / 2;
      return o;
   endfunction

   task automatic send_request(logic act, logic [2:0] idx, logic [11:0] x, logic [11:0] y,
                               logic sos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata <= $urandom;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, y, x, idx};
      req_tuser <= {sos, act};
      do @(posedge clock); while (!req_tready);
      if (act == ACT_LOAD) begin
         model_px[idx] = x;
         model_py[idx] = y;
      end else begin
         pending_outcomes.insert(pending_outcomes.size(), classify_point(x, y, sos));
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_outcomes.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, longint value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[25:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:     cfg_mode = value[0];
         CSR_COUNT:    cfg_count = value[3:0];
         CSR_INIT_REF: cfg_init_ref = longint'($signed(value[25:0]));
         default: ;
      endcase
   endtask

   task automatic configure(logic mode, logic [3:0] count, longint init_ref);
      drain();
      write_csr(CSR_MODE, mode);
      write_csr(CSR_COUNT, count);
      write_csr(CSR_INIT_REF, init_ref);
   endtask

   always @(posedge clock) begin
      outcome_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected response: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            e = pending_outcomes.pop_front();
            if (rsp_tdata[2:0] !== e.cluster) begin
               $error("cluster: expected %0d, actual %0d", e.cluster, rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tuser !== e.matched) begin
               $error("matched: expected %0d, actual %0d", e.matched, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[28:3] !== e.measure) begin
               $error("measure: expected %0d, actual %0d", e.measure,
                      $signed(rsp_tdata[28:3]));
               error_count++;
            end
            if (rsp_tdata[31:29] !== 3'd0) begin
               $error("fill: expected 0, actual %0d", rsp_tdata[31:29]);
               error_count++;
            end
         end
      end
   end

   task automatic test_reset_defaults();
      send_request(ACT_LOAD, 3'd0, 12'd100, 12'd100, 1'b1);
      send_request(ACT_CLASSIFY, 3'd0, 12'd50, 12'd50, 1'b1);
      send_request(ACT_CLASSIFY, 3'd0, 12'd100, 12'd0, 1'b0);
      send_request(ACT_CLASSIFY, 3'd0, 12'd99, 12'd100, 1'b0);
   endtask

   task automatic test_directed_edges();
      send_request(ACT_LOAD, 3'd1, 12'd4095, 12'd4095, 1'b0);
      send_request(ACT_LOAD, 3'd2, 12'd4095, 12'd0, 1'b0);
      send_request(ACT_LOAD, 3'd3, 12'd0, 12'd4095, 1'b0);
      send_request(ACT_LOAD, 3'd4, 12'd2048, 12'd2048, 1'b0);
      send_request(ACT_LOAD, 3'd5, 12'd2048, 12'd0, 1'b0);
      send_request(ACT_LOAD, 3'd6, 12'd1, 12'd2000, 1'b0);
      send_request(ACT_LOAD, 3'd7, 12'd3000, 12'd3001, 1'b0);
      configure(MODE_ANGLE, 4'd8, 90 * FULL);
      send_request(ACT_CLASSIFY, 3'd0, 12'd2048, 12'd2048, 1'b1);
      send_request(ACT_CLASSIFY, 3'd0, 12'd0, 12'd4095, 1'b0);
      configure(MODE_ANGLE, 4'd8, 0);
      send_request(ACT_CLASSIFY, 3'd0, 12'd0, 12'd2048, 1'b1);
      configure(MODE_ANGLE, 4'd15, 135 * FULL);
      send_request(ACT_CLASSIFY, 3'd0, 12'd4095, 12'd0, 1'b1);
      configure(MODE_SLOPE, 4'd8, 1 * FULL);
      send_request(ACT_CLASSIFY, 3'd0, 12'd0, 12'd0, 1'b1);
      send_request(ACT_CLASSIFY, 3'd0, 12'd2048, 12'd10, 1'b0);
      send_request(ACT_CLASSIFY, 3'd0, 12'd4095, 12'd4095, 1'b0);
      configure(MODE_SLOPE, 4'd0, 33554431);
      send_request(ACT_CLASSIFY, 3'd0, 12'd5, 12'd5, 1'b1);
      configure(MODE_SLOPE, 4'd15, -33554432);
      send_request(ACT_CLASSIFY, 3'd0, 12'd4095, 12'd4095, 1'b1);
      send_request(ACT_CLASSIFY, 3'd0, 12'd0, 12'd4095, 1'b1);
   endtask

   task automatic random_point(output logic [11:0] x, output logic [11:0] y);
      int c;
      c = $urandom_range(7);
      if ($urandom_range(1)) begin
         x = model_px[c] + 12'($urandom_range(32) - 16);
         y = model_py[c] + 12'($urandom_range(64) - 32);
      end else begin
         x = $urandom;
         y = $urandom;
      end
   endtask

   task automatic test_random_phases(int phases, int per_phase);
      logic [11:0] x, y;
      logic mode;
      logic [3:0] count;
      longint init_ref;
      for (int p = 0; p < phases; p++) begin
         mode = $urandom_range(1);
         count = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
         if ($urandom_range(9) == 0) init_ref = longint'($signed(26'($urandom)));
         else if (mode) init_ref = longint'($urandom_range(180 * FULL));
         else init_ref = longint'($urandom_range(16 * FULL)) - 8 * FULL;
         configure(mode, count, init_ref);
         for (int i = 0; i < per_phase; i++) begin
            random_point(x, y);
            if ($urandom_range(99) < 12)
               send_request(ACT_LOAD, 3'($urandom), x, y, 1'($urandom));
            else
               send_request(ACT_CLASSIFY, 3'($urandom), x, y,
                            (i == 0) || ($urandom_range(9) == 0));
         end
      end
   endtask

   task automatic test_output_stall();
      logic [11:0] x, y;
      configure(MODE_ANGLE, 4'd2, 45 * FULL);
      @(negedge clock);
      stall_cycles = 3000;
      for (int i = 0; i < 12; i++) begin
         random_point(x, y);
         send_request(ACT_CLASSIFY, 3'd0, x, y, i == 0);
      end
      drain();
      for (int i = 0; i < 12; i++) begin
         random_point(x, y);
         send_request(ACT_CLASSIFY, 3'd0, x, y, 1'b0);
      end
   endtask

   initial begin
      reference = 0;
      cfg_mode = 1'b0;
      cfg_count = 4'd1;
      cfg_init_ref = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_edges();
      test_output_stall();
      test_random_phases(21, 60);
      drain();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
